/* rtl/core/alpha_bounding_box_tracker_top_defines.svh */
// Assertion macros shared by the alpha bounding box tracker RTL.
`ifndef ALPHA_BOUNDING_BOX_TRACKER_TOP_DEFINES_SVH
`define ALPHA_BOUNDING_BOX_TRACKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define ABBT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every clock edge, reset included.
`define ABBT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ABBT_ASSERT(name, prop, msg)
`define ABBT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

/* rtl/core/abbt_pkg.sv */
// Types and constants of the alpha bounding box tracker.
package abbt_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_MAX   = (2 ** CFG_W) - 1;
  localparam int unsigned POS_W     = CFG_W;
  localparam int unsigned ALPHA_W   = 8;
  localparam int unsigned LT_W      = 12;
  localparam int unsigned RB_W      = 13;
  localparam int unsigned EVQ_DEPTH = 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1024);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_UNION = 1'b1
  } box_kind_e;

  // Box of one finished frame, on its way from the front to the back.
  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] bottom;
    logic             transp;
    logic             seq_end;
  } event_t;

  typedef struct packed {
    box_kind_e       kind;
    logic [LT_W-1:0] left;
    logic [LT_W-1:0] top;
    logic [RB_W-1:0] right;
    logic [RB_W-1:0] bottom;
    logic            transp;
    logic            run_end;
  } result_t;

endpackage

/* rtl/core/abbt_front.sv */
// Pixel front end: raster position, per-frame box, frame end events.
module abbt_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [abbt_pkg::CFG_W-1:0]    frame_width_i,
  input  logic [abbt_pkg::CFG_W-1:0]    frame_height_i,
  input  logic                          push_i,
  input  logic [abbt_pkg::ALPHA_W-1:0]  alpha_i,
  input  logic                          sequence_end_i,
  output logic                          full_o,
  input  logic                          evq_full_i,
  output logic                          ev_push_o,
  output abbt_pkg::event_t              ev_o
);
  import abbt_pkg::*;

  localparam int unsigned LIM_W = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
  localparam int unsigned LIM_H = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;

  function automatic logic [POS_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [POS_W-1:0] lim);
    logic [POS_W-1:0] r;
    r = POS_W'(v);
    if (v == '0) begin
      r = POS_W'(1);
    end else if (POS_W'(v) > lim) begin
      r = lim;
    end
    return r;
  endfunction

  logic [POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [POS_W-1:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic [POS_W-1:0] max_x_q, max_x_d, max_y_q, max_y_d;
  logic             seen_q, seen_d;

  logic [POS_W-1:0] w_eff, h_eff, x1, y1;
  logic [POS_W-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
  logic             n_seen, accept, opaque, row_done, frame_done;

  always_comb begin
    w_eff      = clamp_size(frame_width_i, POS_W'(LIM_W));
    h_eff      = clamp_size(frame_height_i, POS_W'(LIM_H));
    accept     = push_i & ~evq_full_i;
    opaque     = (alpha_i != '0);
    x1         = col_q + POS_W'(1);
    y1         = row_q + POS_W'(1);
    row_done   = (x1 >= w_eff);
    frame_done = row_done & (y1 >= h_eff);

    n_min_x = min_x_q;
    n_min_y = min_y_q;
    n_max_x = max_x_q;
    n_max_y = max_y_q;
    n_seen  = seen_q;
    if (opaque) begin
      n_seen = 1'b1;
      if (!seen_q) begin
        n_min_x = col_q;
        n_min_y = row_q;
        n_max_x = x1;
        n_max_y = y1;
      end else begin
        if (col_q < min_x_q) n_min_x = col_q;
        if (row_q < min_y_q) n_min_y = row_q;
        if (x1 > max_x_q) n_max_x = x1;
        if (y1 > max_y_q) n_max_y = y1;
      end
    end

    col_d   = col_q;
    row_d   = row_q;
    min_x_d = min_x_q;
    min_y_d = min_y_q;
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    seen_d  = seen_q;
    if (accept) begin
      if (frame_done) begin
        col_d   = '0;
        row_d   = '0;
        min_x_d = '0;
        min_y_d = '0;
        max_x_d = '0;
        max_y_d = '0;
        seen_d  = 1'b0;
      end else begin
        min_x_d = n_min_x;
        min_y_d = n_min_y;
        max_x_d = n_max_x;
        max_y_d = n_max_y;
        seen_d  = n_seen;
        if (row_done) begin
          col_d = '0;
          row_d = y1;
        end else begin
          col_d = x1;
        end
      end
    end

    ev_push_o      = accept & frame_done;
    ev_o.left      = n_seen ? n_min_x : '0;
    ev_o.top       = n_seen ? n_min_y : '0;
    ev_o.right     = n_seen ? n_max_x : '0;
    ev_o.bottom    = n_seen ? n_max_y : '0;
    ev_o.transp    = ~n_seen;
    ev_o.seq_end   = sequence_end_i;
  end

  assign full_o = evq_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      seen_q  <= seen_d;
    end
  end

`include "alpha_bounding_box_tracker_top_defines.svh"

  `ABBT_ASSERT(front_box_order, seen_q |-> (max_x_q > min_x_q) && (max_y_q > min_y_q), "frame box inverted")
  `ABBT_ASSERT(front_frame_clear, ev_push_o |=> (col_q == '0) && (row_q == '0) && !seen_q, "frame state not cleared")

endmodule

/* rtl/core/abbt_evq.sv */
// Short event queue between the pixel front end and the box back end.
module abbt_evq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  abbt_pkg::event_t data_i,
  output logic             full_o,
  output logic             valid_o,
  output abbt_pkg::event_t data_o,
  input  logic             pop_i
);
  import abbt_pkg::*;

  localparam int unsigned PTR_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(EVQ_DEPTH + 1);

  event_t           mem_q [EVQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(EVQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

`include "alpha_bounding_box_tracker_top_defines.svh"

  `ABBT_ASSERT(evq_cnt_bound, cnt_q <= CNT_W'(EVQ_DEPTH), "event queue count out of range")
  `ABBT_ASSERT(evq_no_overflow, push_i |-> !full_o, "event pushed into full queue")
  `ABBT_ASSERT(evq_no_underflow, pop_i |-> valid_o, "event popped from empty queue")

endmodule

/* rtl/core/abbt_back.sv */
// Box back end: union over the sequence and the registered result stage.
module abbt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  input  abbt_pkg::event_t  ev_i,
  output logic              ev_pop_o,
  output logic              res_valid_o,
  output abbt_pkg::result_t res_o,
  input  logic              pop_i
);
  import abbt_pkg::*;

  logic [POS_W-1:0] u_min_x_q, u_min_x_d, u_min_y_q, u_min_y_d;
  logic [POS_W-1:0] u_max_x_q, u_max_x_d, u_max_y_q, u_max_y_d;
  logic             started_q, started_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  logic             load;

  always_comb begin
    load     = ~out_valid_q | pop_i;
    ev_pop_o = ev_valid_i & load & ~pend_q;

    u_min_x_d   = u_min_x_q;
    u_min_y_d   = u_min_y_q;
    u_max_x_d   = u_max_x_q;
    u_max_y_d   = u_max_y_q;
    started_d   = started_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (load) begin
      if (pend_q) begin
        // Emit the union, then start a new sequence.
        out_valid_d   = 1'b1;
        out_d.kind    = KIND_UNION;
        out_d.left    = LT_W'(u_min_x_q);
        out_d.top     = LT_W'(u_min_y_q);
        out_d.right   = RB_W'(u_max_x_q);
        out_d.bottom  = RB_W'(u_max_y_q);
        out_d.transp  = (u_max_x_q == '0);
        out_d.run_end = 1'b1;
        u_min_x_d     = '0;
        u_min_y_d     = '0;
        u_max_x_d     = '0;
        u_max_y_d     = '0;
        started_d     = 1'b0;
        pend_d        = 1'b0;
      end else if (ev_valid_i) begin
        out_valid_d   = 1'b1;
        out_d.kind    = KIND_FRAME;
        out_d.left    = LT_W'(ev_i.left);
        out_d.top     = LT_W'(ev_i.top);
        out_d.right   = RB_W'(ev_i.right);
        out_d.bottom  = RB_W'(ev_i.bottom);
        out_d.transp  = ev_i.transp;
        out_d.run_end = ~ev_i.seq_end;
        pend_d        = ev_i.seq_end;
        started_d     = 1'b1;
        if (!started_q) begin
          u_min_x_d = ev_i.left;
          u_min_y_d = ev_i.top;
          u_max_x_d = ev_i.right;
          u_max_y_d = ev_i.bottom;
        end else begin
          if (ev_i.left < u_min_x_q) u_min_x_d = ev_i.left;
          if (ev_i.top < u_min_y_q) u_min_y_d = ev_i.top;
          if (ev_i.right > u_max_x_q) u_max_x_d = ev_i.right;
          if (ev_i.bottom > u_max_y_q) u_max_y_d = ev_i.bottom;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_min_x_q   <= '0;
      u_min_y_q   <= '0;
      u_max_x_q   <= '0;
      u_max_y_q   <= '0;
      started_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      u_min_x_q   <= u_min_x_d;
      u_min_y_q   <= u_min_y_d;
      u_max_x_q   <= u_max_x_d;
      u_max_y_q   <= u_max_y_d;
      started_q   <= started_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "alpha_bounding_box_tracker_top_defines.svh"

  `ABBT_ASSERT(back_pend_has_frame, pend_q |-> out_valid_q, "union pending without a frame result")
  `ABBT_ASSERT(back_frame_before_union, $rose(pend_q) |-> !out_q.run_end && (out_q.kind == KIND_FRAME), "frame result before union must not end the run")

endmodule

/* rtl/core/alpha_bounding_box_tracker_top.sv */
// Alpha bounding box tracker: config registers, front end, event queue, back end.
// Takes one alpha pixel per clock in raster order and reports, at the last pixel of each
// frame, the box around all nonzero-alpha pixels (right and bottom exclusive), or a zero
// box flagged fully_transparent; when that pixel carries sequence_end, the union box of
// the sequence follows with box_kind set. The front end takes a pixel every cycle while
// the two-entry event queue has room; the back end drains one event per cycle into a
// registered result stage while it is empty or popped; results leave at one per pop,
// after the event queue and the result register. A sequence end holds back the next
// event for the union box. frame_width and frame_height (APB offsets 0x0 and 0x4)
// are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT and should be changed only while idle.
module alpha_bounding_box_tracker_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [abbt_pkg::APB_AW-1:0]   paddr,
  input  logic [abbt_pkg::APB_DW-1:0]   pwdata,
  output logic [abbt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [abbt_pkg::ALPHA_W-1:0]  alpha_i,
  input  logic                          sequence_end_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          box_kind_o,
  output logic [abbt_pkg::LT_W-1:0]     box_left_o,
  output logic [abbt_pkg::LT_W-1:0]     box_top_o,
  output logic [abbt_pkg::RB_W-1:0]     box_right_o,
  output logic [abbt_pkg::RB_W-1:0]     box_bottom_o,
  output logic                          fully_transparent_o,
  output logic                          run_end_o
);
  import abbt_pkg::*;

  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  logic             evq_full, ev_push, ev_valid, ev_pop, res_valid;
  event_t           ev_in, ev_out;
  result_t          res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (reg_idx)
      REG_FRAME_WIDTH: begin
        prdata = APB_DW'(width_q);
        if (cfg_wr) width_d = pwdata[CFG_W-1:0];
      end
      REG_FRAME_HEIGHT: begin
        prdata = APB_DW'(height_q);
        if (cfg_wr) height_d = pwdata[CFG_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  abbt_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_width_i (width_q),
    .frame_height_i(height_q),
    .push_i        (push),
    .alpha_i       (alpha_i),
    .sequence_end_i(sequence_end_i),
    .full_o        (full),
    .evq_full_i    (evq_full),
    .ev_push_o     (ev_push),
    .ev_o          (ev_in)
  );

  abbt_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ev_push),
    .data_i (ev_in),
    .full_o (evq_full),
    .valid_o(ev_valid),
    .data_o (ev_out),
    .pop_i  (ev_pop)
  );

  abbt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (ev_valid),
    .ev_i       (ev_out),
    .ev_pop_o   (ev_pop),
    .res_valid_o(res_valid),
    .res_o      (res),
    .pop_i      (pop & res_valid)
  );

  assign empty               = ~res_valid;
  assign box_kind_o          = res.kind;
  assign box_left_o          = res.left;
  assign box_top_o           = res.top;
  assign box_right_o         = res.right;
  assign box_bottom_o        = res.bottom;
  assign fully_transparent_o = res.transp;
  assign run_end_o           = res.run_end;

endmodule
